@@ src/fbs_pkg.sv @@
// Package for the flash log end bisect search block.
// Holds widths, codes, phase type and the structs passed between modules.
`timescale 1ns / 1ps

package fbs_pkg;

    localparam int ADDR_BITS   = 24;
    localparam int RECORD_BITS = 23;
    localparam int RECLEN_BITS = 10;
    localparam int BYTE_BITS   = 8;
    localparam int PASS_BITS   = 8;
    localparam int PROD_BITS   = ADDR_BITS + RECLEN_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 23;

    localparam logic [PASS_BITS-1:0] PASS_LIMIT = PASS_BITS'(200);
    localparam logic [BYTE_BITS-1:0] ERASED_RESET = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FIRST = 3'd1,
        PH_LAST  = 3'd2,
        PH_MID   = 3'd3,
        PH_NEXT  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        RK_READ    = 2'd0,
        RK_DONE    = 2'd1,
        RK_IGNORED = 2'd2
    } t_result_kind;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RECORD_LENGTH = 2'd0,
        CFG_MAX_RECORDS   = 2'd1,
        CFG_ERASED_VALUE  = 2'd2
    } t_cfg_index;

    localparam logic REQ_START = 1'b0;

    typedef struct packed {
        logic                 req_type;
        logic [BYTE_BITS-1:0] read_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]             result_kind;
        logic [ADDR_BITS-1:0]   read_address;
        logic [RECORD_BITS-1:0] last_record;
        logic [1:0]             status;
    } t_result;

    typedef struct packed {
        logic [RECLEN_BITS-1:0] record_length;
        logic [RECORD_BITS-1:0] max_records;
        logic [BYTE_BITS-1:0]   erased_value;
    } t_cfg;

endpackage

@@ src/fbs_ifs.sv @@
// Channel interfaces for the flash log end bisect search block.
// Depends on fbs_pkg for payload widths.
`timescale 1ns / 1ps

interface fbs_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [fbs_pkg::BYTE_BITS-1:0] read_byte;

    modport source (output valid, output req_type, output read_byte, input ready);
    modport sink   (input valid, input req_type, input read_byte, output ready);
endinterface

interface fbs_res_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      result_kind;
    logic [fbs_pkg::ADDR_BITS-1:0]   read_address;
    logic [fbs_pkg::RECORD_BITS-1:0] last_record;
    logic [1:0]                      status;

    modport source (output valid, output result_kind, output read_address,
                    output last_record, output status, input ready);
    modport sink   (input valid, input result_kind, input read_address,
                    input last_record, input status, output ready);
endinterface

interface fbs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fbs_pkg::CFG_IDX_BITS-1:0]  index;
    logic [fbs_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/fbs_in_stage.sv @@
// Input register of the search block: one transaction held until the core takes it.
// Depends on fbs_pkg and fbs_req_if.
`timescale 1ns / 1ps

module fbs_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fbs_req_if.sink        i_req,
    input  logic           i_take,
    output logic           o_valid,
    output fbs_pkg::t_item o_item
);

    logic           r_valid;
    fbs_pkg::t_item r_item;

    assign i_req.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_item.req_type  <= i_req.req_type;
            r_item.read_byte <= i_req.read_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ src/fbs_search.sv @@
// Search state and the per-transaction step: bounds, pass count, probe address.
// Depends on fbs_pkg.
`timescale 1ns / 1ps

module fbs_search (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  fbs_pkg::t_item   i_item,
    input  fbs_pkg::t_cfg    i_cfg,
    output fbs_pkg::t_result o_result
);

    fbs_pkg::t_phase                  r_phase, n_phase;
    logic [fbs_pkg::RECORD_BITS-1:0]  r_low, n_low;
    logic [fbs_pkg::RECORD_BITS-1:0]  r_high, n_high;
    logic [fbs_pkg::RECORD_BITS-1:0]  r_probe, n_probe;
    logic                             r_probe_wr, n_probe_wr;
    logic [fbs_pkg::PASS_BITS-1:0]    r_pass, n_pass;

    logic                             w_start;
    logic                             w_written;
    logic                             w_timeout;
    logic                             w_found;
    logic [fbs_pkg::RECORD_BITS-1:0]  w_pass_low, w_pass_high;
    logic [fbs_pkg::RECORD_BITS:0]    w_sum_last, w_sum_next;
    logic [fbs_pkg::RECORD_BITS-1:0]  w_mid_last, w_mid_next;
    logic [fbs_pkg::ADDR_BITS-1:0]    w_rec;
    logic [fbs_pkg::PROD_BITS-1:0]    w_prod;
    logic [1:0]                       w_kind;
    logic [fbs_pkg::RECORD_BITS-1:0]  w_last;
    logic [1:0]                       w_status;

    assign w_start   = (i_item.req_type == fbs_pkg::REQ_START);
    assign w_written = (i_item.read_byte != i_cfg.erased_value);
    assign w_timeout = (r_pass >= fbs_pkg::PASS_LIMIT);

    // Pair outcome: both erased pulls the end down, both written pushes the
    // start up, written then erased is the end, a gap leaves the bounds alone.
    always_comb begin
        w_pass_low  = r_low;
        w_pass_high = r_high;
        w_found     = 1'b0;
        if (!r_probe_wr && !w_written) begin
            w_pass_high = r_probe;
        end else if (r_probe_wr && w_written) begin
            w_pass_low = r_probe;
        end else if (r_probe_wr && !w_written) begin
            w_found = 1'b1;
        end
    end

    assign w_sum_last = (fbs_pkg::RECORD_BITS+1)'(1) + {1'b0, i_cfg.max_records};
    assign w_mid_last = w_sum_last[fbs_pkg::RECORD_BITS:1];
    assign w_sum_next = {1'b0, w_pass_low} + {1'b0, w_pass_high};
    assign w_mid_next = w_sum_next[fbs_pkg::RECORD_BITS:1];

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_start) begin
            n_phase = fbs_pkg::PH_FIRST;
        end else begin
            case (r_phase)
                fbs_pkg::PH_FIRST: begin
                    n_phase = w_written ? fbs_pkg::PH_LAST : fbs_pkg::PH_IDLE;
                end
                fbs_pkg::PH_LAST: begin
                    n_phase = w_written ? fbs_pkg::PH_IDLE : fbs_pkg::PH_MID;
                end
                fbs_pkg::PH_MID: begin
                    n_phase = fbs_pkg::PH_NEXT;
                end
                fbs_pkg::PH_NEXT: begin
                    n_phase = (w_timeout || w_found) ? fbs_pkg::PH_IDLE : fbs_pkg::PH_MID;
                end
                default: begin
                    n_phase = fbs_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Datapath and result
    always_comb begin
        n_low      = r_low;
        n_high     = r_high;
        n_probe    = r_probe;
        n_probe_wr = r_probe_wr;
        n_pass     = r_pass;
        w_rec      = '0;
        w_kind     = fbs_pkg::RK_IGNORED;
        w_last     = '0;
        w_status   = fbs_pkg::ST_FOUND;
        if (w_start) begin
            n_pass     = '0;
            n_probe_wr = 1'b0;
            w_rec      = fbs_pkg::ADDR_BITS'(1);
            w_kind     = fbs_pkg::RK_READ;
        end else begin
            case (r_phase)
                fbs_pkg::PH_FIRST: begin
                    if (!w_written) begin
                        w_kind   = fbs_pkg::RK_DONE;
                        w_status = fbs_pkg::ST_EMPTY;
                    end else begin
                        w_rec  = {1'b0, i_cfg.max_records};
                        w_kind = fbs_pkg::RK_READ;
                    end
                end
                fbs_pkg::PH_LAST: begin
                    if (w_written) begin
                        w_kind   = fbs_pkg::RK_DONE;
                        w_last   = i_cfg.max_records;
                        w_status = fbs_pkg::ST_FULL;
                    end else begin
                        n_low   = fbs_pkg::RECORD_BITS'(1);
                        n_high  = i_cfg.max_records;
                        n_pass  = '0;
                        n_probe = w_mid_last;
                        w_rec   = {1'b0, w_mid_last};
                        w_kind  = fbs_pkg::RK_READ;
                    end
                end
                fbs_pkg::PH_MID: begin
                    n_probe_wr = w_written;
                    w_rec      = {1'b0, r_probe} + fbs_pkg::ADDR_BITS'(1);
                    w_kind     = fbs_pkg::RK_READ;
                end
                fbs_pkg::PH_NEXT: begin
                    n_low  = w_pass_low;
                    n_high = w_pass_high;
                    if (w_timeout) begin
                        w_kind   = fbs_pkg::RK_DONE;
                        w_status = fbs_pkg::ST_TIMEOUT;
                    end else if (w_found) begin
                        w_kind = fbs_pkg::RK_DONE;
                        w_last = r_probe;
                    end else begin
                        n_pass  = r_pass + fbs_pkg::PASS_BITS'(1);
                        n_probe = w_mid_next;
                        w_rec   = {1'b0, w_mid_next};
                        w_kind  = fbs_pkg::RK_READ;
                    end
                end
                default: begin
                    w_kind = fbs_pkg::RK_IGNORED;
                end
            endcase
        end
    end

    // Record to byte address; w_rec is zero whenever no read is issued
    assign w_prod = fbs_pkg::PROD_BITS'(w_rec) * fbs_pkg::PROD_BITS'(i_cfg.record_length);
    assign o_result = {w_kind, w_prod[fbs_pkg::ADDR_BITS-1:0], w_last, w_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= fbs_pkg::PH_IDLE;
            r_low      <= '0;
            r_high     <= '0;
            r_probe    <= '0;
            r_probe_wr <= 1'b0;
            r_pass     <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_low      <= n_low;
            r_high     <= n_high;
            r_probe    <= n_probe;
            r_probe_wr <= n_probe_wr;
            r_pass     <= n_pass;
        end
    end

endmodule

@@ src/fbs_out_stage.sv @@
// Result register of the search block, drives the result channel.
// Depends on fbs_pkg and fbs_res_if.
`timescale 1ns / 1ps

module fbs_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fbs_pkg::t_result i_result,
    output logic             o_ready,
    fbs_res_if.source        o_res
);

    logic             r_valid;
    fbs_pkg::t_result r_result;

    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.result_kind  = r_result.result_kind;
    assign o_res.read_address = r_result.read_address;
    assign o_res.last_record  = r_result.last_record;
    assign o_res.status       = r_result.status;

endmodule

@@ src/flash_log_end_bisect_search.sv @@
// Top level of the flash log end bisect search block: config registers and stages.
// Depends on fbs_pkg, the channel interfaces, fbs_in_stage, fbs_search, fbs_out_stage.
//
// Usage:
//   i_req carries requests: req_type 0 starts a search, 1 returns the byte read
//   from the address most recently issued. o_res gives exactly one transaction per
//   request: a read address (result_kind 0), a done with last_record and status
//   (result_kind 1), or an ignore (result_kind 2) for read data while idle.
//   i_cfg writes record_length (0), max_records (1), erased_value (2); it is
//   always ready and is meant to be written only while the block is idle.
//   Path: a request accepted on i_req waits in the input register, then passes
//   through the search step and one multiply into the result register once
//   that register can take it, and its result is then offered on o_res.
//   Throughput: one request per cycle while the result register can take it;
//   the search state updates in the same cycle the result register loads.
//   Reset: phase idle, bounds and pass count zero, registers at record_length 1,
//   max_records 1, erased_value 0xFF; no clearing pass.
//   A stalled o_res holds its result; i_req keeps accepting until both the
//   result and input registers are full, then ready drops.
`timescale 1ns / 1ps

module flash_log_end_bisect_search (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fbs_req_if.sink   i_req,
    fbs_cfg_if.sink   i_cfg,
    fbs_res_if.source o_res
);

    fbs_pkg::t_cfg    r_cfg;
    logic             w_in_valid;
    fbs_pkg::t_item   w_item;
    logic             w_out_ready;
    logic             w_fire;
    fbs_pkg::t_result w_result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_length <= fbs_pkg::RECLEN_BITS'(1);
            r_cfg.max_records   <= fbs_pkg::RECORD_BITS'(1);
            r_cfg.erased_value  <= fbs_pkg::ERASED_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                fbs_pkg::CFG_RECORD_LENGTH: begin
                    r_cfg.record_length <= i_cfg.data[fbs_pkg::RECLEN_BITS-1:0];
                end
                fbs_pkg::CFG_MAX_RECORDS: begin
                    r_cfg.max_records <= i_cfg.data[fbs_pkg::RECORD_BITS-1:0];
                end
                fbs_pkg::CFG_ERASED_VALUE: begin
                    r_cfg.erased_value <= i_cfg.data[fbs_pkg::BYTE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_fire = w_in_valid && w_out_ready;

    fbs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (w_out_ready),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    fbs_search u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    fbs_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_in_valid),
        .i_result (w_result),
        .o_ready  (w_out_ready),
        .o_res    (o_res)
    );

endmodule

@@ dv/fbs_bisect_checker.sv @@
// Checker for flash_log_end_bisect_search: watches the request, register and result
// channels, tracks the search on its own and compares each result transaction.
// Depends on fbs_pkg and the channel interfaces of src/fbs_ifs.sv.
`timescale 1ns / 1ps

module fbs_bisect_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fbs_req_if   req_ch,
    fbs_res_if   res_ch,
    fbs_cfg_if   cfg_ch,
    output int   o_errors,
    output int   o_pending
);
    import fbs_pkg::*;

    // shadow registers
    logic [RECLEN_BITS-1:0] rec_len;
    logic [RECORD_BITS-1:0] max_rec;
    logic [BYTE_BITS-1:0]   erased;

    // shadow search state
    t_phase                 phase;
    logic [RECORD_BITS-1:0] lo_rec;
    logic [RECORD_BITS-1:0] hi_rec;
    logic [RECORD_BITS-1:0] mid_rec;
    logic                   mid_written;
    logic [PASS_BITS-1:0]   passes;

    t_result expected_flash_ops[$];
    int      errors = 0;

    function automatic logic [ADDR_BITS-1:0] byte_addr(input logic [RECORD_BITS:0] rec);
        logic [RECORD_BITS+RECLEN_BITS:0] prod;
        prod = rec * rec_len;
        return prod[ADDR_BITS-1:0];
    endfunction

    function automatic t_result make_op(input t_result_kind kind,
                                        input logic [ADDR_BITS-1:0] addr,
                                        input logic [RECORD_BITS-1:0] last,
                                        input t_status st);
        t_result r;
        r.result_kind  = kind;
        r.read_address = addr;
        r.last_record  = last;
        r.status       = st;
        return r;
    endfunction

    function automatic t_result begin_pass();
        logic [RECORD_BITS:0] sum;
        sum     = lo_rec + hi_rec;
        mid_rec = sum[RECORD_BITS:1];
        phase   = PH_MID;
        return make_op(RK_READ, byte_addr({1'b0, mid_rec}), '0, ST_FOUND);
    endfunction

    // One request in, the flash read or verdict it should produce out.
    function automatic t_result bisect_step(input logic req_type,
                                            input logic [BYTE_BITS-1:0] rd);
        logic written;
        logic found;
        written = (rd != erased);
        found   = 1'b0;
        if (req_type == REQ_START) begin
            passes      = '0;
            mid_written = 1'b0;
            phase       = PH_FIRST;
            return make_op(RK_READ, byte_addr(1), '0, ST_FOUND);
        end
        case (phase)
            PH_FIRST: begin
                if (!written) begin
                    phase = PH_IDLE;
                    return make_op(RK_DONE, '0, '0, ST_EMPTY);
                end
                phase = PH_LAST;
                return make_op(RK_READ, byte_addr({1'b0, max_rec}), '0, ST_FOUND);
            end
            PH_LAST: begin
                if (written) begin
                    phase = PH_IDLE;
                    return make_op(RK_DONE, '0, max_rec, ST_FULL);
                end
                lo_rec = 1;
                hi_rec = max_rec;
                passes = '0;
                return begin_pass();
            end
            PH_MID: begin
                mid_written = written;
                phase       = PH_NEXT;
                return make_op(RK_READ, byte_addr({1'b0, mid_rec} + 1'b1), '0, ST_FOUND);
            end
            PH_NEXT: begin
                if (!mid_written && !written)
                    hi_rec = mid_rec;
                else if (mid_written && written)
                    lo_rec = mid_rec;
                else if (mid_written && !written)
                    found = 1'b1;
                // pass limit wins over a find on the same pass
                if (passes >= PASS_LIMIT) begin
                    phase = PH_IDLE;
                    return make_op(RK_DONE, '0, '0, ST_TIMEOUT);
                end
                if (found) begin
                    phase = PH_IDLE;
                    return make_op(RK_DONE, '0, mid_rec, ST_FOUND);
                end
                passes = passes + 1'b1;
                return begin_pass();
            end
            default: begin
                phase = PH_IDLE;
                return make_op(RK_IGNORED, '0, '0, ST_FOUND);
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            rec_len     = 1;
            max_rec     = 1;
            erased      = ERASED_RESET;
            phase       = PH_IDLE;
            lo_rec      = '0;
            hi_rec      = '0;
            mid_rec     = '0;
            mid_written = 1'b0;
            passes      = '0;
            expected_flash_ops.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_RECORD_LENGTH: rec_len = cfg_ch.data[RECLEN_BITS-1:0];
                    CFG_MAX_RECORDS:   max_rec = cfg_ch.data[RECORD_BITS-1:0];
                    CFG_ERASED_VALUE:  erased  = cfg_ch.data[BYTE_BITS-1:0];
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
                expected_flash_ops.push_back(bisect_step(req_ch.req_type, req_ch.read_byte));
            if (res_ch.valid && res_ch.ready) begin
                if (expected_flash_ops.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual kind %0d addr %0h",
                             $time, res_ch.result_kind, res_ch.read_address);
                end else begin
                    want = expected_flash_ops.pop_front();
                    check_field("result_kind", want.result_kind, res_ch.result_kind);
                    check_field("read_address", want.read_address, res_ch.read_address);
                    check_field("last_record", want.last_record, res_ch.last_record);
                    check_field("status", want.status, res_ch.status);
                end
            end
        end
        o_errors  <= errors;
        o_pending <= expected_flash_ops.size();
    end

endmodule

@@ dv/tb_flash_log_end_bisect_search.sv @@
// Testbench top for flash_log_end_bisect_search: drives search requests and flash
// bytes, register writes and result back-pressure; fbs_bisect_checker does the checks.
// Depends on fbs_pkg, src/fbs_ifs.sv, the block and dv/fbs_bisect_checker.sv.
`timescale 1ns / 1ps

module tb_flash_log_end_bisect_search;
    import fbs_pkg::*;

    localparam logic                    REQ_READ    = 1'b1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE   = 2'd3;
    localparam int                      STALL_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fbs_req_if req_ch ();
    fbs_res_if res_ch ();
    fbs_cfg_if cfg_ch ();

    int                   err_count;
    int                   pending_count;
    int                   items_sent = 0;
    int                   burst_left = 0;
    int                   quiet_cycles = 0;
    logic [BYTE_BITS-1:0] erased_now = ERASED_RESET;

    always #10 i_clk = ~i_clk;

    flash_log_end_bisect_search uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    fbs_bisect_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req_ch    (req_ch),
        .res_ch    (res_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (err_count),
        .o_pending (pending_count)
    );

    // Watchdog: nothing moving on any channel for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: stall patterns in segments, plus two long hold-offs.
    initial begin
        int hold_left;
        int mode;
        int mode_left;
        int served;
        int long_holds;
        hold_left  = 0;
        mode       = 0;
        mode_left  = 0;
        served     = 0;
        long_holds = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                served++;
            if (long_holds < 2 && served >= 150 + 350 * long_holds) begin
                long_holds++;
                hold_left = $urandom_range(60, 100);
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [BYTE_BITS-1:0] flash_byte(input bit written);
        logic [BYTE_BITS-1:0] b;
        if (!written)
            return erased_now;
        do
            b = BYTE_BITS'($urandom);
        while (b == erased_now);
        return b;
    endfunction

    // Holds the request until accepted; valid drops only when a burst ends.
    task automatic offer(input logic rtype, input logic [BYTE_BITS-1:0] rd);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rtype;
        req_ch.read_byte <= rd;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap        = $urandom_range(0, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending until every result is back, then let the pipeline settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_BITS-1:0] len_data,
                            input logic [CFG_DATA_BITS-1:0] max_data,
                            input logic [CFG_DATA_BITS-1:0] erased_data);
        drain();
        write_reg(CFG_MAX_RECORDS, max_data);
        write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
        write_reg(CFG_ERASED_VALUE, erased_data);
        write_reg(CFG_RECORD_LENGTH, len_data);
        cfg_ch.valid <= 1'b0;
        erased_now = erased_data[BYTE_BITS-1:0];
    endtask

    // One search as a host would run it. Pair codes per pass:
    // <40 erased/erased, <80 written/written, <92 written/erased (end), else gap.
    task automatic run_search(input bit to_timeout);
        int roll;
        int pass;
        bit first_w;
        bit second_w;
        offer(REQ_START, BYTE_BITS'($urandom));
        roll = $urandom_range(0, 99);
        if (!to_timeout && roll < 12) begin
            offer(REQ_READ, flash_byte(1'b0));
            return;
        end
        offer(REQ_READ, flash_byte(1'b1));
        if (!to_timeout && roll < 24) begin
            offer(REQ_READ, flash_byte(1'b1));
            return;
        end
        offer(REQ_READ, flash_byte(1'b0));
        for (pass = 0; pass <= int'(PASS_LIMIT); pass++) begin
            roll = $urandom_range(0, 99);
            // timeout run: gaps only, and an end found on the very last pass
            if (to_timeout)
                roll = (pass < int'(PASS_LIMIT)) ? 95 : 85;
            else if (roll < 3) begin
                // abandoned mid-pass; a later start interrupts it
                offer(REQ_READ, flash_byte($urandom_range(0, 1)));
                return;
            end
            first_w  = (roll >= 40 && roll < 92);
            second_w = (roll >= 40 && roll < 80) || roll >= 92;
            offer(REQ_READ, flash_byte(first_w));
            offer(REQ_READ, flash_byte(second_w));
            if (first_w && !second_w)
                return;
        end
    endtask

    task automatic run_random(input int n, input bit with_timeout);
        int goal;
        int roll;
        goal = items_sent + n;
        if (with_timeout)
            run_search(1'b1);
        while (items_sent < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                offer(REQ_READ, BYTE_BITS'($urandom));
            else if (roll < 14)
                drain();
            else
                run_search(1'b0);
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_START;
        req_ch.read_byte <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_RECORD_LENGTH;
        cfg_ch.data      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, on reset register values
        offer(REQ_READ, 8'h00);                         // flash data while idle
        offer(REQ_START, 8'hFF);
        offer(REQ_READ, 8'hFF);                         // empty log
        offer(REQ_START, 8'h00);
        offer(REQ_READ, 8'h00);
        offer(REQ_READ, 8'h7F);                         // full log
        offer(REQ_START, 8'h55);
        offer(REQ_READ, 8'h80);
        offer(REQ_READ, 8'hFF);
        offer(REQ_READ, 8'hFF);
        offer(REQ_READ, 8'hFF);                         // erased pair, end moves down
        offer(REQ_READ, 8'h01);
        offer(REQ_READ, 8'hFE);                         // written pair, start moves up
        offer(REQ_READ, 8'hFF);
        offer(REQ_READ, 8'h00);                         // gap, bounds unchanged
        offer(REQ_READ, 8'hAA);
        offer(REQ_READ, 8'hFF);                         // end found
        offer(REQ_START, 8'h0F);
        offer(REQ_READ, 8'hF0);
        offer(REQ_READ, 8'hFF);
        offer(REQ_READ, 8'h33);
        offer(REQ_START, 8'hCC);                        // restart while busy
        offer(REQ_READ, 8'hFF);
        offer(REQ_READ, 8'h3C);

        // largest record length and record count; address wraps
        set_regs({13'($urandom), 10'd1023}, 23'h7FFFFF, {15'($urandom), 8'h00});
        run_random(60, 1'b0);
        set_regs(23'd1, 23'd1, 23'd255);
        run_random(60, 1'b0);
        // record length and count of zero
        set_regs({13'($urandom), 10'd0}, 23'd0, 23'($urandom));
        run_random(40, 1'b0);
        set_regs(23'($urandom), 23'($urandom_range(2, 64)), 23'($urandom));
        run_random(60, 1'b1);
        set_regs(23'($urandom), 23'($urandom), 23'($urandom));
        run_random(80, 1'b0);
        set_regs({13'd0, 10'($urandom_range(1, 1023))}, 23'($urandom_range(1, 300)), 23'hFF);
        run_random(100, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
